>>> src/circular_arc_path_evaluator_unit_macros.svh
// Assertion macros of the arc evaluator, used by cavu_queue.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef CIRCULAR_ARC_PATH_EVALUATOR_UNIT_MACROS_SVH
`define CIRCULAR_ARC_PATH_EVALUATOR_UNIT_MACROS_SVH
`ifndef SYNTH
`define CAVU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("cavu check failed");
`define CAVU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("cavu check failed");
`else
`define CAVU_ASSERT_IMP(lbl, ante, cons)
`define CAVU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> src/cavu_pkg.sv
// Package of the circular arc evaluator: constants, types and helper functions.
// No dependencies.
package cavu_pkg;
	localparam int CORDIC_STAGES = 24;
	localparam int FRAC_BITS = 16;
	localparam int UNIT_FRAC = 14;
	localparam int DIR_FRAC = 28;
	localparam int TAN_SHIFT = DIR_FRAC - FRAC_BITS;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam int QUEUE_DEPTH = 4;
	localparam int BACK_LAT = CORDIC_STAGES + 6;

	typedef enum logic [2:0] {
		REG_CENTER_X = 3'd0,
		REG_CENTER_Y = 3'd1,
		REG_CENTER_Z = 3'd2,
		REG_RADIAL = 3'd3,
		REG_TANGENT = 3'd4,
		REG_RADIUS = 3'd5,
		REG_INV_RADIUS = 3'd6,
		REG_TURNS = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic [47:0] radial_unit_packed;
		logic [47:0] tangent_unit_packed;
		logic [30:0] circle_radius;
		logic [31:0] inverse_radius;
		logic [47:0] turns_per_length;
	} frame_cfg_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic signed [31:0] acc_x;
		logic signed [31:0] acc_y;
		logic signed [31:0] acc_z;
	} result_t;

	// Arctangent of 2^-i in phase units, one turn = 2^32.
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'd536870912;
			1: r = 32'd316933406;
			2: r = 32'd167458907;
			3: r = 32'd85004756;
			4: r = 32'd42667331;
			5: r = 32'd21354465;
			6: r = 32'd10679838;
			7: r = 32'd5340245;
			8: r = 32'd2670163;
			9: r = 32'd1335087;
			10: r = 32'd667544;
			11: r = 32'd333772;
			12: r = 32'd166886;
			13: r = 32'd83443;
			14: r = 32'd41722;
			15: r = 32'd20861;
			16: r = 32'd10430;
			17: r = 32'd5215;
			18: r = 32'd2608;
			19: r = 32'd1304;
			20: r = 32'd652;
			21: r = 32'd326;
			22: r = 32'd163;
			23: r = 32'd81;
			24: r = 32'd41;
			25: r = 32'd20;
			26: r = 32'd10;
			27: r = 32'd5;
			28: r = 32'd3;
			29: r = 32'd1;
			30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// Clamp a wide signed value to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
		logic signed [31:0] r;
		if (v > 72'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -72'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction
endpackage

>>> src/cavu_if.sv
// Channel interfaces of the arc evaluator: input item, result item, register write.
// Depends on cavu_pkg.
interface cavu_in_if;
	logic valid;
	logic ready;
	logic signed [31:0] arc_length;
	modport source (output valid, output arc_length, input ready);
	modport sink (input valid, input arc_length, output ready);
endinterface

interface cavu_out_if import cavu_pkg::*; ;
	logic valid;
	logic ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic signed [31:0] vel_z;
	logic signed [31:0] acc_x;
	logic signed [31:0] acc_y;
	logic signed [31:0] acc_z;
	modport source (output valid, output pos_x, output pos_y, output pos_z,
		output vel_x, output vel_y, output vel_z, output acc_x, output acc_y,
		output acc_z, input ready);
	modport sink (input valid, input pos_x, input pos_y, input pos_z,
		input vel_x, input vel_y, input vel_z, input acc_x, input acc_y,
		input acc_z, output ready);
endinterface

interface cavu_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [47:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/cavu_front.sv
// Front end: accepts arc lengths and maps them to 32-bit phase in two stages.
// Depends on cavu_pkg.
module cavu_front import cavu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic signed [31:0] arc_length,
	input logic [47:0] turns_per_length,
	output logic ph_valid,
	input logic ph_ready,
	output logic [31:0] phase
);
	logic adv;
	logic valid_s1, valid_s2;
	logic signed [56:0] lo_s1, hi_s1;
	logic [31:0] phase_s2;
	logic signed [63:0] sum;

	// Whole front moves when its last stage is empty or drains.
	assign adv = !valid_s2 || ph_ready;
	assign in_ready = adv;

	// Split product: two 32 by 25 multiplies.
	always_ff @(posedge clk) begin
		if (adv) begin
			lo_s1 <= 57'(arc_length * $signed({1'b0, turns_per_length[23:0]}));
			hi_s1 <= 57'(arc_length * $signed({1'b0, turns_per_length[47:24]}));
		end
	end

	assign sum = 64'(lo_s1) + (64'(hi_s1) <<< 24);

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_s2 <= sum[FRAC_BITS+31:FRAC_BITS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	assign ph_valid = valid_s2;
	assign phase = phase_s2;
endmodule

>>> src/cavu_queue.sv
// Short phase queue between the front and back ends.
// Depends on cavu_pkg and the assertion macro header.
`include "circular_arc_path_evaluator_unit_macros.svh"
module cavu_queue import cavu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input logic [31:0] push_data,
	output logic pop_valid,
	input logic pop_ready,
	output logic [31:0] pop_data
);
	localparam int PW = $clog2(QUEUE_DEPTH);
	logic [31:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0] cnt_q;
	logic push, pop;

	assign push_ready = cnt_q != (PW+1)'(QUEUE_DEPTH);
	assign pop_valid = cnt_q != '0;
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_data = mem_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`CAVU_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= (PW+1)'(QUEUE_DEPTH))
	`CAVU_ASSERT_NXT(a_pop_only, pop && !push, cnt_q == $past(cnt_q) - 1'b1)
	`CAVU_ASSERT_NXT(a_push_only, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
endmodule

>>> src/cavu_cordic.sv
// Pipelined rotation-mode CORDIC, one stage per iteration, with a common enable.
// Depends on cavu_pkg.
module cavu_cordic import cavu_pkg::*; (
	input logic clk,
	input logic en,
	input logic [31:0] phase,
	output logic signed [33:0] x_out,
	output logic signed [33:0] y_out,
	output logic [1:0] quad_out
);
	logic signed [33:0] x_q [CORDIC_STAGES];
	logic signed [33:0] y_q [CORDIC_STAGES];
	logic signed [32:0] z_q [CORDIC_STAGES];
	logic [1:0] qd_q [CORDIC_STAGES];

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		logic signed [33:0] xi, yi;
		logic signed [32:0] zi, at;
		logic [1:0] qi;
		// Stage input comes from the phase or from the stage before.
		if (i == 0) begin : g_first
			assign xi = CORDIC_GAIN;
			assign yi = '0;
			assign zi = $signed({3'b000, phase[29:0]});
			assign qi = phase[31:30];
		end else begin : g_next
			assign xi = x_q[i-1];
			assign yi = y_q[i-1];
			assign zi = z_q[i-1];
			assign qi = qd_q[i-1];
		end
		assign at = $signed({1'b0, atan_turn(i)});
		always_ff @(posedge clk) begin
			if (en) begin
				if (!zi[32]) begin
					x_q[i] <= xi - (yi >>> i);
					y_q[i] <= yi + (xi >>> i);
					z_q[i] <= zi - at;
				end else begin
					x_q[i] <= xi + (yi >>> i);
					y_q[i] <= yi - (xi >>> i);
					z_q[i] <= zi + at;
				end
				qd_q[i] <= qi;
			end
		end
	end

	assign x_out = x_q[CORDIC_STAGES-1];
	assign y_out = y_q[CORDIC_STAGES-1];
	assign quad_out = qd_q[CORDIC_STAGES-1];
endmodule

>>> src/cavu_back.sv
// Back end: CORDIC, frame products, rounding and saturation into the output register.
// Depends on cavu_pkg and cavu_cordic.
module cavu_back import cavu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic ph_valid,
	output logic ph_ready,
	input logic [31:0] phase,
	input frame_cfg_t cfg,
	output logic res_valid,
	input logic res_ready,
	output result_t res
);
	logic adv;
	logic [BACK_LAT-1:0] vld_q;
	logic signed [33:0] cx, cy;
	logic [1:0] quad;
	logic signed [18:0] xr, yr;
	logic signed [18:0] cs_s1, sn_s1;
	logic signed [31:0] pos_s6 [3];
	logic signed [31:0] vel_s6 [3];
	logic signed [31:0] acc_s6 [3];

	// The whole back end advances unless a finished result is held.
	assign adv = !vld_q[BACK_LAT-1] || res_ready;
	assign ph_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[BACK_LAT-2:0], ph_valid};
		end
	end

	cavu_cordic u_cordic (
		.clk(clk),
		.en(adv),
		.phase(phase),
		.x_out(cx),
		.y_out(cy),
		.quad_out(quad)
	);

	// Round to Q2.14 and unfold the quadrant.
	assign xr = 19'((cx + 34'sd32768) >>> (30 - UNIT_FRAC));
	assign yr = 19'((cy + 34'sd32768) >>> (30 - UNIT_FRAC));

	always_ff @(posedge clk) begin
		if (adv) begin
			case (quad)
				2'd0: begin
					cs_s1 <= xr;
					sn_s1 <= yr;
				end
				2'd1: begin
					cs_s1 <= -yr;
					sn_s1 <= xr;
				end
				2'd2: begin
					cs_s1 <= -xr;
					sn_s1 <= -yr;
				end
				default: begin
					cs_s1 <= yr;
					sn_s1 <= -xr;
				end
			endcase
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_axis
		logic signed [15:0] u, v;
		logic signed [31:0] ctr;
		logic signed [34:0] cu_s2, sv_s2, cv_s2, su_s2;
		logic signed [35:0] dir_s3, tan_s3, tan_s4;
		logic signed [52:0] prl_s4, prh_s4, pil_s4, pih_s4;
		logic signed [71:0] p_s5, a_s5;
		logic signed [31:0] vel_s5;
		logic signed [71:0] tan_r, p_r, a_r;

		assign u = cfg.radial_unit_packed[16*k +: 16];
		assign v = cfg.tangent_unit_packed[16*k +: 16];
		assign ctr = (k == 0) ? cfg.center_x : ((k == 1) ? cfg.center_y : cfg.center_z);
		assign tan_r = (72'(tan_s4) + (72'sd1 <<< (TAN_SHIFT - 1))) >>> TAN_SHIFT;
		assign p_r = (p_s5 + (72'sd1 <<< (DIR_FRAC - 1))) >>> DIR_FRAC;
		assign a_r = (a_s5 + (72'sd1 <<< (DIR_FRAC - 1))) >>> DIR_FRAC;

		always_ff @(posedge clk) begin
			if (adv) begin
				// Sine and cosine against the frame vectors.
				cu_s2 <= 35'(cs_s1 * u);
				sv_s2 <= 35'(sn_s1 * v);
				cv_s2 <= 35'(cs_s1 * v);
				su_s2 <= 35'(sn_s1 * u);
				// Radial direction and tangent.
				dir_s3 <= 36'(cu_s2) + 36'(sv_s2);
				tan_s3 <= 36'(cv_s2) - 36'(su_s2);
				// Scale by radius and reciprocal radius, each split at bit 16.
				prl_s4 <= 53'(dir_s3 * $signed({1'b0, cfg.circle_radius[15:0]}));
				prh_s4 <= 53'(dir_s3 * $signed({1'b0, cfg.circle_radius[30:16]}));
				pil_s4 <= 53'(dir_s3 * $signed({1'b0, cfg.inverse_radius[15:0]}));
				pih_s4 <= 53'(dir_s3 * $signed({1'b0, cfg.inverse_radius[31:16]}));
				tan_s4 <= tan_s3;
				// Reassemble the halves; acceleration points inward.
				p_s5 <= 72'(prl_s4) + (72'(prh_s4) <<< 16);
				a_s5 <= -(72'(pil_s4) + (72'(pih_s4) <<< 16));
				vel_s5 <= sat32(tan_r);
				// Round, offset by the center and saturate.
				pos_s6[k] <= sat32(72'(ctr) + p_r);
				acc_s6[k] <= sat32(a_r);
				vel_s6[k] <= vel_s5;
			end
		end
	end

	assign res_valid = vld_q[BACK_LAT-1];
	assign res.pos_x = pos_s6[0];
	assign res.pos_y = pos_s6[1];
	assign res.pos_z = pos_s6[2];
	assign res.vel_x = vel_s6[0];
	assign res.vel_y = vel_s6[1];
	assign res.vel_z = vel_s6[2];
	assign res.acc_x = acc_s6[0];
	assign res.acc_y = acc_s6[1];
	assign res.acc_z = acc_s6[2];
endmodule

>>> src/circular_arc_path_evaluator_unit.sv
// Top level of the circular arc evaluator: register file, front, queue and back end.
// Depends on cavu_pkg, cavu_if, cavu_front, cavu_queue and cavu_back.
//
// Usage: software writes the circle frame through the cfg channel (index 0..7:
// center x/y/z, packed radial and tangent unit vectors, radius, reciprocal radius,
// turns per length); cfg.ready is always high and a write takes effect at once.
// Writes must be made while no item is in flight; the block does not enforce this.
// Each item on arc_in is one signed Q16.16 arc length; each carries exactly one
// result on arc_out: position, unit tangent and acceleration, Q16.16.
// Throughput is one item per cycle while arc_out does not stall. From acceptance to a
// valid result an item passes two phase stages, the queue, the CORDIC pipeline,
// rounding, and five product and rounding stages.
// When arc_out stalls, the back end holds; the four-entry queue and the front keep
// accepting until both fill, then arc_in.ready drops.
// Reset clears all valid state and loads the frame with unit radius and reciprocal radius and zeros.
module circular_arc_path_evaluator_unit import cavu_pkg::*; (
	input logic clk,
	input logic arst_n,
	cavu_in_if.sink arc_in,
	cavu_out_if.source arc_out,
	cavu_cfg_if.sink cfg
);
	frame_cfg_t frame_q;
	logic ph_valid, ph_ready, bk_valid, bk_ready;
	logic [31:0] ph_data, bk_data;
	result_t res;

	assign cfg.ready = 1'b1;

	// Frame registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '{center_x: '0, center_y: '0, center_z: '0,
				radial_unit_packed: '0, tangent_unit_packed: '0,
				circle_radius: 31'd65536, inverse_radius: 32'd65536,
				turns_per_length: '0};
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_CENTER_X: frame_q.center_x <= cfg.data[31:0];
				REG_CENTER_Y: frame_q.center_y <= cfg.data[31:0];
				REG_CENTER_Z: frame_q.center_z <= cfg.data[31:0];
				REG_RADIAL: frame_q.radial_unit_packed <= cfg.data;
				REG_TANGENT: frame_q.tangent_unit_packed <= cfg.data;
				REG_RADIUS: frame_q.circle_radius <= cfg.data[30:0];
				REG_INV_RADIUS: frame_q.inverse_radius <= cfg.data[31:0];
				REG_TURNS: frame_q.turns_per_length <= cfg.data;
				default: ;
			endcase
		end
	end

	cavu_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(arc_in.valid),
		.in_ready(arc_in.ready),
		.arc_length(arc_in.arc_length),
		.turns_per_length(frame_q.turns_per_length),
		.ph_valid(ph_valid),
		.ph_ready(ph_ready),
		.phase(ph_data)
	);

	cavu_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(ph_valid),
		.push_ready(ph_ready),
		.push_data(ph_data),
		.pop_valid(bk_valid),
		.pop_ready(bk_ready),
		.pop_data(bk_data)
	);

	cavu_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.ph_valid(bk_valid),
		.ph_ready(bk_ready),
		.phase(bk_data),
		.cfg(frame_q),
		.res_valid(arc_out.valid),
		.res_ready(arc_out.ready),
		.res(res)
	);

	assign arc_out.pos_x = res.pos_x;
	assign arc_out.pos_y = res.pos_y;
	assign arc_out.pos_z = res.pos_z;
	assign arc_out.vel_x = res.vel_x;
	assign arc_out.vel_y = res.vel_y;
	assign arc_out.vel_z = res.vel_z;
	assign arc_out.acc_x = res.acc_x;
	assign arc_out.acc_y = res.acc_y;
	assign arc_out.acc_z = res.acc_z;
endmodule
